@@ src/udrb_pkg.sv @@
// ----------------------------------------------------------------------------
// UART dual ring buffer package
// Shared sizes, operation and status codes, and the request, response and
// memory command structures of the dual ring buffer.
// ----------------------------------------------------------------------------
package udrb_pkg;

   // Ring sizes. Each ring keeps one slot unused, so it holds depth - 1 bytes.
   localparam int RX_DEPTH = 64;
   localparam int TX_DEPTH = 64;
   localparam int RX_PTR_W = $clog2(RX_DEPTH);
   localparam int TX_PTR_W = $clog2(TX_DEPTH);

   // Operation codes of a request.
   localparam logic [1:0] OP_PUT     = 2'd0;
   localparam logic [1:0] OP_GET     = 2'd1;
   localparam logic [1:0] OP_SERVICE = 2'd2;

   // Status codes of a response.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_TX_FULL  = 2'd1;
   localparam logic [1:0] ST_RX_EMPTY = 2'd2;

   // One request.
   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] put_byte;
      logic       rx_ready;
      logic       tx_empty;
      logic       line_error;
      logic [7:0] incoming_byte;
   } req_type;

   // One response.
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] got_byte;
      logic       send_valid;
      logic [7:0] send_byte;
      logic       tx_irq_enabled;
      logic       rx_dropped;
      logic       error_drained;
   } rsp_type;

   // Accesses issued by the control logic to the two ring memories.
   typedef struct packed {
      logic                tx_wr_en;
      logic [TX_PTR_W-1:0] tx_wr_addr;
      logic [7:0]          tx_wr_data;
      logic                tx_rd_en;
      logic [TX_PTR_W-1:0] tx_rd_addr;
      logic                rx_wr_en;
      logic [RX_PTR_W-1:0] rx_wr_addr;
      logic [7:0]          rx_wr_data;
      logic                rx_rd_en;
      logic [RX_PTR_W-1:0] rx_rd_addr;
   } mem_cmd_type;

endpackage

@@ src/udrb_ram.sv @@
// ----------------------------------------------------------------------------
// Ring storage
// Simple dual-port memory: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module udrb_ram #(
   parameter  int DEPTH = 64,
   parameter  int WIDTH = 8,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/udrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// Ring control
// Request register, ring pointer logic, interrupt enable and response
// register of the dual ring buffer.
// ----------------------------------------------------------------------------
module udrb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  udrb_pkg::req_type     req_payload,
   output udrb_pkg::mem_cmd_type mem_cmd,
   input  logic [7:0]            rx_rd_data,
   input  logic [7:0]            tx_rd_data,
   output logic                  rsp_strobe,
   output udrb_pkg::rsp_type     rsp_payload
);

   localparam logic [udrb_pkg::RX_PTR_W-1:0] RX_LAST =
      udrb_pkg::RX_PTR_W'(udrb_pkg::RX_DEPTH - 1);
   localparam logic [udrb_pkg::TX_PTR_W-1:0] TX_LAST =
      udrb_pkg::TX_PTR_W'(udrb_pkg::TX_DEPTH - 1);

   udrb_pkg::req_type               req_ff;
   logic                            req_valid_ff;
   logic [udrb_pkg::RX_PTR_W-1:0]   rx_head_ff, rx_head_in;
   logic [udrb_pkg::RX_PTR_W-1:0]   rx_tail_ff, rx_tail_in;
   logic [udrb_pkg::TX_PTR_W-1:0]   tx_head_ff, tx_head_in;
   logic [udrb_pkg::TX_PTR_W-1:0]   tx_tail_ff, tx_tail_in;
   logic                            tx_irq_on_ff, tx_irq_on_in;
   logic                            rsp_valid_ff;
   logic [1:0]                      status_ff, status_in;
   logic                            got_sel_ff, got_sel_in;
   logic                            send_sel_ff, send_sel_in;
   logic                            drop_ff, drop_in;
   logic                            drain_ff, drain_in;

   logic [udrb_pkg::RX_PTR_W-1:0]   rx_head_next, rx_tail_next;
   logic [udrb_pkg::TX_PTR_W-1:0]   tx_head_next, tx_tail_next;
   logic                            rx_full, rx_empty, tx_full, tx_empty;

   // Every cycle takes a new request.
   assign busy = 1'b0;

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
      req_ff <= req_payload;
   end

   // Wrapped pointer increments and ring conditions.
   assign rx_head_next = (rx_head_ff == RX_LAST) ? '0 : rx_head_ff + 1'b1;
   assign rx_tail_next = (rx_tail_ff == RX_LAST) ? '0 : rx_tail_ff + 1'b1;
   assign tx_head_next = (tx_head_ff == TX_LAST) ? '0 : tx_head_ff + 1'b1;
   assign tx_tail_next = (tx_tail_ff == TX_LAST) ? '0 : tx_tail_ff + 1'b1;
   assign rx_full  = (rx_head_next == rx_tail_ff);
   assign rx_empty = (rx_head_ff == rx_tail_ff);
   assign tx_full  = (tx_head_next == tx_tail_ff);
   assign tx_empty = (tx_head_ff == tx_tail_ff);

   // Decode of the registered request into pointer moves and memory accesses.
   always_comb begin
      rx_head_in   = rx_head_ff;
      rx_tail_in   = rx_tail_ff;
      tx_head_in   = tx_head_ff;
      tx_tail_in   = tx_tail_ff;
      tx_irq_on_in = tx_irq_on_ff;
      status_in    = udrb_pkg::ST_OK;
      got_sel_in   = 1'b0;
      send_sel_in  = 1'b0;
      drop_in      = 1'b0;
      drain_in     = 1'b0;

      mem_cmd            = '0;
      mem_cmd.tx_wr_addr = tx_head_ff;
      mem_cmd.tx_wr_data = req_ff.put_byte;
      mem_cmd.tx_rd_addr = tx_tail_ff;
      mem_cmd.rx_wr_addr = rx_head_ff;
      mem_cmd.rx_wr_data = req_ff.incoming_byte;
      mem_cmd.rx_rd_addr = rx_tail_ff;

      if (req_valid_ff) begin
         case (req_ff.operation)
            udrb_pkg::OP_PUT: begin
               if (tx_full) begin
                  status_in = udrb_pkg::ST_TX_FULL;
               end else begin
                  mem_cmd.tx_wr_en = 1'b1;
                  tx_head_in       = tx_head_next;
                  tx_irq_on_in     = 1'b1;
               end
            end
            udrb_pkg::OP_GET: begin
               if (rx_empty) begin
                  status_in = udrb_pkg::ST_RX_EMPTY;
               end else begin
                  mem_cmd.rx_rd_en = 1'b1;
                  got_sel_in       = 1'b1;
                  rx_tail_in       = rx_tail_next;
               end
            end
            udrb_pkg::OP_SERVICE: begin
               // Receive side: store the byte unless the ring is full.
               if (req_ff.rx_ready) begin
                  if (rx_full) begin
                     drop_in = 1'b1;
                  end else begin
                     mem_cmd.rx_wr_en = 1'b1;
                     rx_head_in       = rx_head_next;
                  end
               end
               // Transmit side: send the next byte or turn the interrupt off.
               if (req_ff.tx_empty) begin
                  if (tx_empty) begin
                     tx_irq_on_in = 1'b0;
                  end else begin
                     mem_cmd.tx_rd_en = 1'b1;
                     send_sel_in      = 1'b1;
                     tx_tail_in       = tx_tail_next;
                  end
               end
               drain_in = req_ff.line_error;
            end
            default: begin
               // The unused code leaves everything as it is.
            end
         endcase
      end
   end

   // Ring state and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff   <= '0;
         rx_tail_ff   <= '0;
         tx_head_ff   <= '0;
         tx_tail_ff   <= '0;
         tx_irq_on_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rx_head_ff   <= rx_head_in;
         rx_tail_ff   <= rx_tail_in;
         tx_head_ff   <= tx_head_in;
         tx_tail_ff   <= tx_tail_in;
         tx_irq_on_ff <= tx_irq_on_in;
         rsp_valid_ff <= req_valid_ff;
      end
      status_ff   <= status_in;
      got_sel_ff  <= got_sel_in;
      send_sel_ff <= send_sel_in;
      drop_ff     <= drop_in;
      drain_ff    <= drain_in;
   end

   // Response assembly; memory read data arrives with the response register.
   assign rsp_strobe                 = rsp_valid_ff;
   assign rsp_payload.status         = status_ff;
   assign rsp_payload.got_byte       = got_sel_ff ? rx_rd_data : 8'h00;
   assign rsp_payload.send_valid     = send_sel_ff;
   assign rsp_payload.send_byte      = send_sel_ff ? tx_rd_data : 8'h00;
   assign rsp_payload.tx_irq_enabled = tx_irq_on_ff;
   assign rsp_payload.rx_dropped     = drop_ff;
   assign rsp_payload.error_drained  = drain_ff;

endmodule

@@ src/uart_dual_ring_buffer.sv @@
// ----------------------------------------------------------------------------
// UART dual ring buffer
// Transmit and receive byte rings with put, get and interrupt service
// requests, one response for each request.
// ----------------------------------------------------------------------------
//
//   Channel    Ports                        Handshake
//   request    start, busy, req_payload     taken when start high, busy low
//   response   rsp_strobe, rsp_payload      shown for one cycle, no back-pressure
//
// A request is taken in every cycle; busy stays low.
// A request reaches the response ports through the request register, then the
// pointer logic with at most one access to each ring memory, then the
// response register. The memory read data is registered with the response,
// so a request uses each memory port at most once.
// Synchronous reset empties both rings and turns the transmit interrupt on.
// ----------------------------------------------------------------------------
module uart_dual_ring_buffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  udrb_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output udrb_pkg::rsp_type rsp_payload
);

   udrb_pkg::mem_cmd_type mem_cmd;
   logic [7:0]            rx_rd_data;
   logic [7:0]            tx_rd_data;

   // Pointer logic and response register.
   udrb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .mem_cmd     (mem_cmd),
      .rx_rd_data  (rx_rd_data),
      .tx_rd_data  (tx_rd_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // Receive ring storage.
   udrb_ram #(
      .DEPTH (udrb_pkg::RX_DEPTH),
      .WIDTH (8)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (mem_cmd.rx_wr_en),
      .wr_addr (mem_cmd.rx_wr_addr),
      .wr_data (mem_cmd.rx_wr_data),
      .rd_en   (mem_cmd.rx_rd_en),
      .rd_addr (mem_cmd.rx_rd_addr),
      .rd_data (rx_rd_data)
   );

   // Transmit ring storage.
   udrb_ram #(
      .DEPTH (udrb_pkg::TX_DEPTH),
      .WIDTH (8)
   ) u_tx_ram (
      .clock   (clock),
      .wr_en   (mem_cmd.tx_wr_en),
      .wr_addr (mem_cmd.tx_wr_addr),
      .wr_data (mem_cmd.tx_wr_data),
      .rd_en   (mem_cmd.tx_rd_en),
      .rd_addr (mem_cmd.tx_rd_addr),
      .rd_data (tx_rd_data)
   );

   // A response only follows a request that has passed the request and response registers.
   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("response without a matching request");

   // A request taken outside reset always gets its response.
   a_request_answered: assert property (@(posedge clock) disable iff (reset)
      ($past(start && !busy, 2) && !$past(reset) && !$past(reset, 2)) |-> rsp_strobe)
      else $error("request lost");

   // A queued byte keeps the transmit interrupt on, so a send shows it on.
   a_send_irq_on: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.send_valid) |-> rsp_payload.tx_irq_enabled)
      else $error("byte sent with transmit interrupt off");

   // A full transmit ring holds bytes, so the interrupt must be on.
   a_full_irq_on: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.status == udrb_pkg::ST_TX_FULL)
         |-> rsp_payload.tx_irq_enabled)
      else $error("transmit ring full with interrupt off");

endmodule

@@ verif/udrb_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// Dual ring buffer scoreboard
// Keeps a cycle-free copy of both byte rings and the transmit interrupt
// enable, works out the response of every accepted request and compares
// the responses of the block against them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package udrb_tb_pkg;

   import udrb_pkg::*;

   // The fourth operation code has no meaning and must leave the rings alone.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   class ring_scoreboard;

      logic [7:0]          rx_ring [RX_DEPTH];
      logic [7:0]          tx_ring [TX_DEPTH];
      logic [RX_PTR_W-1:0] rx_wr_ptr;
      logic [RX_PTR_W-1:0] rx_rd_ptr;
      logic [TX_PTR_W-1:0] tx_wr_ptr;
      logic [TX_PTR_W-1:0] tx_rd_ptr;
      logic                irq_on;
      rsp_type             pending [$];

      int unsigned errors;
      int unsigned puts;
      int unsigned overruns;
      int unsigned gets;
      int unsigned empties;
      int unsigned sends;
      int unsigned drops;
      int unsigned drains;

      // Both rings start empty with the transmit interrupt enabled.
      function new();
         rx_wr_ptr = '0;
         rx_rd_ptr = '0;
         tx_wr_ptr = '0;
         tx_rd_ptr = '0;
         irq_on    = 1'b1;
         errors    = 0;
         puts      = 0;
         overruns  = 0;
         gets      = 0;
         empties   = 0;
         sends     = 0;
         drops     = 0;
         drains    = 0;
      endfunction

      function logic [RX_PTR_W-1:0] rx_advance(logic [RX_PTR_W-1:0] ptr);
         return (ptr == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : ptr + 1'b1;
      endfunction

      function logic [TX_PTR_W-1:0] tx_advance(logic [TX_PTR_W-1:0] ptr);
         return (ptr == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : ptr + 1'b1;
      endfunction

      // Apply one accepted request to the ring copies and queue its response.
      function void note_request(req_type req);
         rsp_type want;
         want        = '0;
         want.status = ST_OK;
         case (req.operation)
            OP_PUT: begin
               if (tx_advance(tx_wr_ptr) == tx_rd_ptr) begin
                  want.status = ST_TX_FULL;
                  overruns++;
               end else begin
                  tx_ring[tx_wr_ptr] = req.put_byte;
                  tx_wr_ptr          = tx_advance(tx_wr_ptr);
                  irq_on             = 1'b1;
                  puts++;
               end
            end
            OP_GET: begin
               if (rx_rd_ptr == rx_wr_ptr) begin
                  want.status = ST_RX_EMPTY;
                  empties++;
               end else begin
                  want.got_byte = rx_ring[rx_rd_ptr];
                  rx_rd_ptr     = rx_advance(rx_rd_ptr);
                  gets++;
               end
            end
            OP_SERVICE: begin
               // Receive first, then transmit, then the line error.
               if (req.rx_ready) begin
                  if (rx_advance(rx_wr_ptr) == rx_rd_ptr) begin
                     want.rx_dropped = 1'b1;
                     drops++;
                  end else begin
                     rx_ring[rx_wr_ptr] = req.incoming_byte;
                     rx_wr_ptr          = rx_advance(rx_wr_ptr);
                  end
               end
               if (req.tx_empty) begin
                  if (tx_rd_ptr == tx_wr_ptr) begin
                     irq_on = 1'b0;
                  end else begin
                     want.send_valid = 1'b1;
                     want.send_byte  = tx_ring[tx_rd_ptr];
                     tx_rd_ptr       = tx_advance(tx_rd_ptr);
                     sends++;
                  end
               end
               if (req.line_error) begin
                  want.error_drained = 1'b1;
                  drains++;
               end
            end
            default: begin
            end
         endcase
         want.tx_irq_enabled = irq_on;
         pending.push_back(want);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      // Match one response of the block against the oldest expectation.
      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $error("response 0x%0h arrived with no request outstanding", got);
            errors++;
            return;
         end
         want = pending.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("got_byte", want.got_byte, got.got_byte);
         compare_field("send_valid", want.send_valid, got.send_valid);
         compare_field("send_byte", want.send_byte, got.send_byte);
         compare_field("tx_irq_enabled", want.tx_irq_enabled, got.tx_irq_enabled);
         compare_field("rx_dropped", want.rx_dropped, got.rx_dropped);
         compare_field("error_drained", want.error_drained, got.error_drained);
      endfunction

   endclass

endpackage

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Dual ring buffer testbench
// Drives put, get and interrupt service requests into the ring buffer, first
// a directed set around empty rings, extremes and the unused operation, then
// bursts that fill and drain both rings under varying request gaps. Every
// response is checked against the scoreboard in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   import udrb_pkg::*;
   import udrb_tb_pkg::*;

   localparam int ITEMS_PER_PHASE = 180;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SETTLE_CYCLES   = 4;

   // Traffic shapes of the random part.
   localparam int MIX_NOISE   = 0;
   localparam int MIX_FILL_TX = 1;
   localparam int MIX_FILL_RX = 2;
   localparam int MIX_DRAIN   = 3;

   logic    clock;
   logic    reset       = 1'b1;
   logic    start       = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   ring_scoreboard sb;
   int unsigned    stalled_cycles = 0;
   int unsigned    sent_requests  = 0;

   uart_dual_ring_buffer dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // 12 ns clock.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Every response is checked as it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         sb.check_response(rsp_payload);
      end
   end

   // End the run when neither a request nor a response moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   function automatic req_type make_req(logic [1:0] op, logic [7:0] put_byte,
                                        logic rx_ready, logic tx_empty,
                                        logic line_error, logic [7:0] incoming_byte);
      req_type req;
      req.operation     = op;
      req.put_byte      = put_byte;
      req.rx_ready      = rx_ready;
      req.tx_empty      = tx_empty;
      req.line_error    = line_error;
      req.incoming_byte = incoming_byte;
      return req;
   endfunction

   // Present one request after a random gap and wait until it is taken.
   task automatic send_request(input req_type req, input int idle_pct);
      @(negedge clock);
      while ($urandom_range(99, 0) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start       = 1'b1;
      req_payload = req;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      sb.note_request(req);
      sent_requests++;
   endtask

   // Empty rings, both byte extremes, every operation and the status mixes.
   task automatic run_directed(input int idle_pct);
      send_request(make_req(OP_GET, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00), idle_pct);
      send_request(make_req(OP_SERVICE, 8'h00, 1'b0, 1'b1, 1'b0, 8'h00), idle_pct);
      send_request(make_req(OP_UNUSED, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00), idle_pct);
      send_request(make_req(OP_PUT, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00), idle_pct);
      send_request(make_req(OP_PUT, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF), idle_pct);
      send_request(make_req(OP_SERVICE, 8'hFF, 1'b0, 1'b0, 1'b0, 8'hFF), idle_pct);
      send_request(make_req(OP_SERVICE, 8'h00, 1'b0, 1'b1, 1'b0, 8'h00), idle_pct);
      send_request(make_req(OP_SERVICE, 8'h00, 1'b1, 1'b1, 1'b0, 8'hFF), idle_pct);
      send_request(make_req(OP_SERVICE, 8'h00, 1'b1, 1'b0, 1'b1, 8'h00), idle_pct);
      send_request(make_req(OP_GET, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF), idle_pct);
      send_request(make_req(OP_GET, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00), idle_pct);
      send_request(make_req(OP_GET, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00), idle_pct);
      send_request(make_req(OP_SERVICE, 8'h00, 1'b0, 1'b0, 1'b1, 8'hA5), idle_pct);
      send_request(make_req(OP_PUT, 8'h5A, 1'b0, 1'b0, 1'b0, 8'h00), idle_pct);
      send_request(make_req(OP_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF), idle_pct);
      send_request(make_req(OP_SERVICE, 8'h00, 1'b1, 1'b1, 1'b1, 8'h3C), idle_pct);
      send_request(make_req(OP_SERVICE, 8'h00, 1'b0, 1'b1, 1'b0, 8'h00), idle_pct);
      send_request(make_req(OP_UNUSED, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00), idle_pct);
      send_request(make_req(OP_GET, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00), idle_pct);
   endtask

   // One random request shaped by the current traffic mix.
   function automatic req_type traffic_item(input int mix);
      req_type req;
      req = make_req(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)),
                     1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                     1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)));
      case (mix)
         MIX_FILL_TX: begin
            req.operation = OP_PUT;
         end
         MIX_FILL_RX: begin
            req.operation  = OP_SERVICE;
            req.rx_ready   = 1'b1;
            req.tx_empty   = ($urandom_range(3, 0) == 0);
            req.line_error = ($urandom_range(7, 0) == 0);
         end
         MIX_DRAIN: begin
            req.operation = $urandom_range(1, 0) ? OP_GET : OP_SERVICE;
            req.rx_ready  = 1'b0;
            req.tx_empty  = 1'b1;
         end
         default: begin
         end
      endcase
      return req;
   endfunction

   // Bursts that overrun, fill, drain and scramble the rings.
   task automatic run_traffic(input int idle_pct, input int count);
      int done;
      int mix;
      int burst;
      done = 0;
      while (done < count) begin
         mix = $urandom_range(3, 0);
         case (mix)
            MIX_FILL_TX: burst = $urandom_range(80, 60);
            MIX_FILL_RX: burst = $urandom_range(80, 60);
            MIX_DRAIN:   burst = $urandom_range(90, 40);
            default:     burst = $urandom_range(24, 8);
         endcase
         // The last burst of a phase stops at the phase's request count.
         if (burst > count - done) begin
            burst = count - done;
         end
         repeat (burst) begin
            send_request(traffic_item(mix), idle_pct);
         end
         done += burst;
      end
   endtask

   // Reset, three idle settings, then wait for the last response.
   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed(31);
      run_traffic(31, ITEMS_PER_PHASE);
      run_traffic(51, ITEMS_PER_PHASE);
      run_traffic(0, ITEMS_PER_PHASE);

      @(negedge clock);
      start = 1'b0;
      while (sb.pending.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d requests: %0d bytes queued, %0d transmit overruns,",
               sent_requests, sb.puts, sb.overruns);
      $display("%0d bytes fetched, %0d empty fetches, %0d bytes sent,",
               sb.gets, sb.empties, sb.sends);
      $display("%0d received bytes dropped and %0d line errors drained.",
               sb.drops, sb.drains);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
